[sv/sgpr_pkg.sv]
// shared types, codes and the 5x7 font table of the glyph page renderer
// no dependencies; used by sgpr_ctrl, sgpr_dp and the top level
package sgpr_pkg;

    // stretch mode taken from the scale field of a character beat
    typedef enum logic [1:0] {
        MODE_RAW = 2'd0,
        MODE_X8  = 2'd1,
        MODE_X4  = 2'd2,
        MODE_X2  = 2'd3
    } t_mode;

    // input opcodes and output kinds
    localparam logic OPC_SETPOS = 1'b0;
    localparam logic OPC_PUTCH  = 1'b1;
    localparam logic KIND_RUN   = 1'b0;
    localparam logic KIND_POS   = 1'b1;

    // printable range of the font
    localparam logic [7:0] CHAR_FIRST = 8'h20;
    localparam logic [7:0] CHAR_LAST  = 8'h7f;

    // column advance after a stretched glyph
    localparam logic [7:0] STEP_X8 = 8'd48;
    localparam logic [7:0] STEP_X4 = 8'd24;
    localparam logic [7:0] STEP_X2 = 8'd12;

    // repeat counts of a run
    localparam logic [3:0] REP_X8  = 4'd8;
    localparam logic [3:0] REP_X4  = 4'd3;
    localparam logic [3:0] REP_X2  = 4'd2;
    localparam logic [3:0] REP_ONE = 4'd1;

    // glyph columns (five lit plus one blank spacer)
    localparam logic [2:0] LAST_COL = 3'd5;

    // datapath commands issued by the controller
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_SETPOS = 3'd2,
        OP_RUN    = 3'd3,
        OP_ROWPOS = 3'd4,
        OP_FINAL  = 3'd5
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        t_mode      mode;
        logic [2:0] col;
        logic [2:0] row;
        logic       sub;
        logic       last;
    } t_dp_cmd;

    // five column bytes, index 0 is the leftmost column, bit0 at the top
    typedef logic [0:4][7:0] t_glyph;

    function automatic t_mode scale_mode(input logic [3:0] scale);
        t_mode m;
        unique case (scale)
            4'd8:    m = MODE_X8;
            4'd4:    m = MODE_X4;
            4'd2:    m = MODE_X2;
            default: m = MODE_RAW;
        endcase
        return m;
    endfunction

    // index is the character code minus 0x20
    function automatic t_glyph font_glyph(input logic [6:0] idx);
        t_glyph g;
        case (idx)
            7'd0:  g = 40'h0000000000;
            7'd1:  g = 40'h00005f0000;
            7'd2:  g = 40'h0007000700;
            7'd3:  g = 40'h147f147f14;
            7'd4:  g = 40'h242a7f2a12;
            7'd5:  g = 40'h2313086462;
            7'd6:  g = 40'h3649552250;
            7'd7:  g = 40'h0005030000;
            7'd8:  g = 40'h001c224100;
            7'd9:  g = 40'h0041221c00;
            7'd10: g = 40'h14083e0814;
            7'd11: g = 40'h08083e0808;
            7'd12: g = 40'h0050300000;
            7'd13: g = 40'h0808080808;
            7'd14: g = 40'h0060600000;
            7'd15: g = 40'h2010080402;
            7'd16: g = 40'h3e5149453e;
            7'd17: g = 40'h00427f4000;
            7'd18: g = 40'h4261514946;
            7'd19: g = 40'h2141454b31;
            7'd20: g = 40'h1814127f10;
            7'd21: g = 40'h2745454539;
            7'd22: g = 40'h3c4a494930;
            7'd23: g = 40'h0171090503;
            7'd24: g = 40'h3649494936;
            7'd25: g = 40'h064949291e;
            7'd26: g = 40'h0036360000;
            7'd27: g = 40'h0056360000;
            7'd28: g = 40'h0814224100;
            7'd29: g = 40'h1414141414;
            7'd30: g = 40'h0041221408;
            7'd31: g = 40'h0201510906;
            7'd32: g = 40'h324979413e;
            7'd33: g = 40'h7e1111117e;
            7'd34: g = 40'h7f49494936;
            7'd35: g = 40'h3e41414122;
            7'd36: g = 40'h7f4141221c;
            7'd37: g = 40'h7f49494941;
            7'd38: g = 40'h7f09090901;
            7'd39: g = 40'h3e4149497a;
            7'd40: g = 40'h7f0808087f;
            7'd41: g = 40'h00417f4100;
            7'd42: g = 40'h2040413f01;
            7'd43: g = 40'h7f08142241;
            7'd44: g = 40'h7f40404040;
            7'd45: g = 40'h7f020c027f;
            7'd46: g = 40'h7f0408107f;
            7'd47: g = 40'h3e4141413e;
            7'd48: g = 40'h7f09090906;
            7'd49: g = 40'h3e4151215e;
            7'd50: g = 40'h7f09192946;
            7'd51: g = 40'h4649494931;
            7'd52: g = 40'h01017f0101;
            7'd53: g = 40'h3f4040403f;
            7'd54: g = 40'h1f2040201f;
            7'd55: g = 40'h3f4038403f;
            7'd56: g = 40'h6314081463;
            7'd57: g = 40'h0708700807;
            7'd58: g = 40'h6151494543;
            7'd59: g = 40'h007f414100;
            7'd60: g = 40'h0204081020;
            7'd61: g = 40'h0041417f00;
            7'd62: g = 40'h0402010204;
            7'd63: g = 40'h4040404040;
            7'd64: g = 40'h0001020400;
            7'd65: g = 40'h2054545478;
            7'd66: g = 40'h7f48444438;
            7'd67: g = 40'h3844444420;
            7'd68: g = 40'h384444487f;
            7'd69: g = 40'h3854545418;
            7'd70: g = 40'h087e090102;
            7'd71: g = 40'h0c5252523e;
            7'd72: g = 40'h7f08040478;
            7'd73: g = 40'h00447d4000;
            7'd74: g = 40'h2040443d00;
            7'd75: g = 40'h7f10284400;
            7'd76: g = 40'h00417f4000;
            7'd77: g = 40'h7c04180478;
            7'd78: g = 40'h7c08040478;
            7'd79: g = 40'h3844444438;
            7'd80: g = 40'h7c14141408;
            7'd81: g = 40'h081414187c;
            7'd82: g = 40'h7c08040408;
            7'd83: g = 40'h4854545420;
            7'd84: g = 40'h043f444020;
            7'd85: g = 40'h3c4040207c;
            7'd86: g = 40'h1c2040201c;
            7'd87: g = 40'h3c4030403c;
            7'd88: g = 40'h4428102844;
            7'd89: g = 40'h0c5050503c;
            7'd90: g = 40'h4464544c44;
            7'd91: g = 40'h08082a0808;
            7'd92: g = 40'h00007f0000;
            7'd93: g = 40'h0041360800;
            7'd94: g = 40'h1008081008;
            7'd95: g = 40'h7846414678;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

endpackage

[sv/sgpr_ctrl.sv]
// sequencer of the glyph page renderer: item decode, row and column counters
// depends on sgpr_pkg; drives sgpr_dp through a t_dp_cmd
module sgpr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_opcode,
    input  logic [7:0]           i_char_code,
    input  logic [3:0]           i_scale,
    input  logic                 i_out_free,
    output logic                 o_in_ready,
    output sgpr_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SETPOS = 6'b000010,
        S_RAW    = 6'b000100,
        S_RUN    = 6'b001000,
        S_ROWEND = 6'b010000,
        S_FINAL  = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    sgpr_pkg::t_mode r_mode, n_mode;
    logic [2:0]      r_col, n_col;
    logic [2:0]      r_row, n_row;
    logic            r_sub, n_sub;

    logic            accept;
    logic            in_range;
    logic            emit;
    logic [2:0]      row_max;
    sgpr_pkg::t_mode in_mode;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = (i_char_code >= sgpr_pkg::CHAR_FIRST)
                     && (i_char_code <= sgpr_pkg::CHAR_LAST);
    assign in_mode    = sgpr_pkg::scale_mode(i_scale);
    assign emit       = i_out_free && (r_state != S_IDLE);

    always_comb begin
        unique case (r_mode)
            sgpr_pkg::MODE_X8: row_max = 3'd7;
            sgpr_pkg::MODE_X4: row_max = 3'd3;
            sgpr_pkg::MODE_X2: row_max = 3'd1;
            default:           row_max = 3'd0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_col   = r_col;
        n_row   = r_row;
        n_sub   = r_sub;
        o_cmd   = '{op: sgpr_pkg::OP_NONE, mode: r_mode, col: r_col, row: r_row,
                    sub: r_sub, last: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                n_col = '0;
                n_row = '0;
                n_sub = 1'b0;
                if (accept) begin
                    o_cmd.op = sgpr_pkg::OP_LOAD;
                    n_mode   = in_mode;
                    if (i_opcode == sgpr_pkg::OPC_SETPOS) begin
                        n_state = S_SETPOS;
                    end else if (in_range) begin
                        n_state = (in_mode == sgpr_pkg::MODE_RAW) ? S_RAW : S_RUN;
                    end
                end
            end
            S_SETPOS: begin
                o_cmd.last = 1'b1;
                if (emit) begin
                    o_cmd.op = sgpr_pkg::OP_SETPOS;
                    n_state  = S_IDLE;
                end
            end
            S_RAW: begin
                o_cmd.last = (r_col == sgpr_pkg::LAST_COL);
                if (emit) begin
                    o_cmd.op = sgpr_pkg::OP_RUN;
                    if (r_col == sgpr_pkg::LAST_COL) begin
                        n_state = S_IDLE;
                    end else begin
                        n_col = r_col + 3'd1;
                    end
                end
            end
            S_RUN: begin
                if (emit) begin
                    o_cmd.op = sgpr_pkg::OP_RUN;
                    if (r_mode == sgpr_pkg::MODE_X4 && !r_sub) begin
                        n_sub = 1'b1;
                    end else begin
                        n_sub = 1'b0;
                        if (r_col == sgpr_pkg::LAST_COL) begin
                            n_col   = '0;
                            n_state = S_ROWEND;
                        end else begin
                            n_col = r_col + 3'd1;
                        end
                    end
                end
            end
            S_ROWEND: begin
                if (emit) begin
                    o_cmd.op = sgpr_pkg::OP_ROWPOS;
                    if (r_row == row_max) begin
                        n_state = S_FINAL;
                    end else begin
                        n_row   = r_row + 3'd1;
                        n_state = S_RUN;
                    end
                end
            end
            S_FINAL: begin
                o_cmd.last = 1'b1;
                if (emit) begin
                    o_cmd.op = sgpr_pkg::OP_FINAL;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= sgpr_pkg::MODE_RAW;
            r_col   <= '0;
            r_row   <= '0;
            r_sub   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_col   <= n_col;
            r_row   <= n_row;
            r_sub   <= n_sub;
        end
    end

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= sgpr_pkg::LAST_COL)
        else $error("column counter beyond spacer column");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= row_max)
        else $error("row counter beyond last page row of the mode");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && o_cmd.last) |=> (r_state == S_IDLE))
        else $error("closing beat issued but sequencer not idle");

endmodule

[sv/sgpr_dp.sv]
// datapath of the glyph page renderer: glyph register, cursor, output register
// depends on sgpr_pkg; commanded by sgpr_ctrl
module sgpr_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sgpr_pkg::t_dp_cmd  i_cmd,
    input  logic [7:0]         i_char_code,
    input  logic [7:0]         i_target_column,
    input  logic [2:0]         i_target_page,
    input  logic               i_out_ready,
    output logic               o_out_free,
    output logic               o_out_valid,
    output logic               o_kind,
    output logic [7:0]         o_data_byte,
    output logic [3:0]         o_repeat_count,
    output logic [7:0]         o_out_column,
    output logic [2:0]         o_out_page,
    output logic               o_last
);

    sgpr_pkg::t_glyph r_glyph;
    logic [7:0]       r_tgt_col;
    logic [2:0]       r_tgt_page;
    logic [2:0]       r_start_page;
    logic [7:0]       r_cur_col;
    logic [2:0]       r_cur_page;

    logic             r_valid;
    logic             r_kind;
    logic [7:0]       r_data;
    logic [3:0]       r_rep;
    logic [7:0]       r_col;
    logic [2:0]       r_page;
    logic             r_last;

    logic [7:0]       gcol;
    logic [7:0]       stretched;
    logic [7:0]       run_data;
    logic [3:0]       run_rep;
    logic [7:0]       step;
    logic [3:0]       nib;
    logic             load;

    assign o_out_free = !r_valid || i_out_ready;
    assign load = (i_cmd.op == sgpr_pkg::OP_SETPOS) || (i_cmd.op == sgpr_pkg::OP_RUN)
               || (i_cmd.op == sgpr_pkg::OP_ROWPOS) || (i_cmd.op == sgpr_pkg::OP_FINAL);

    // glyph column, blank spacer in the sixth place
    always_comb begin
        case (i_cmd.col)
            3'd0:    gcol = r_glyph[0];
            3'd1:    gcol = r_glyph[1];
            3'd2:    gcol = r_glyph[2];
            3'd3:    gcol = r_glyph[3];
            3'd4:    gcol = r_glyph[4];
            default: gcol = 8'h00;
        endcase
    end

    assign nib = i_cmd.row[0] ? gcol[7:4] : gcol[3:0];

    always_comb begin
        case (i_cmd.mode)
            sgpr_pkg::MODE_X8: begin
                stretched = {8{gcol[i_cmd.row]}};
                run_rep   = sgpr_pkg::REP_X8;
                step      = sgpr_pkg::STEP_X8;
            end
            sgpr_pkg::MODE_X4: begin
                stretched = {1'b0, {3{gcol[{i_cmd.row[1:0], 1'b1}]}},
                             1'b0, {3{gcol[{i_cmd.row[1:0], 1'b0}]}}};
                run_rep   = sgpr_pkg::REP_X4;
                step      = sgpr_pkg::STEP_X4;
            end
            sgpr_pkg::MODE_X2: begin
                stretched = {{2{nib[3]}}, {2{nib[2]}}, {2{nib[1]}}, {2{nib[0]}}};
                run_rep   = sgpr_pkg::REP_X2;
                step      = sgpr_pkg::STEP_X2;
            end
            default: begin
                stretched = gcol;
                run_rep   = sgpr_pkg::REP_ONE;
                step      = 8'd0;
            end
        endcase
    end

    // the blank column after a 4x stretched run
    always_comb begin
        if (i_cmd.mode == sgpr_pkg::MODE_X4 && i_cmd.sub) begin
            run_data = 8'h00;
        end else begin
            run_data = stretched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == sgpr_pkg::OP_LOAD) begin
            r_glyph      <= sgpr_pkg::font_glyph(i_char_code[6:0] - 7'h20);
            r_tgt_col    <= i_target_column;
            r_tgt_page   <= i_target_page;
            r_start_page <= r_cur_page;
        end
        if (load) begin
            r_last <= i_cmd.last;
            if (i_cmd.op == sgpr_pkg::OP_RUN) begin
                r_kind <= sgpr_pkg::KIND_RUN;
                r_data <= run_data;
                r_rep  <= (i_cmd.mode == sgpr_pkg::MODE_X4 && i_cmd.sub)
                          ? sgpr_pkg::REP_ONE : run_rep;
                r_col  <= '0;
                r_page <= '0;
            end else begin
                r_kind <= sgpr_pkg::KIND_POS;
                r_data <= '0;
                r_rep  <= '0;
                case (i_cmd.op)
                    sgpr_pkg::OP_SETPOS: begin
                        r_col  <= r_tgt_col;
                        r_page <= r_tgt_page;
                    end
                    sgpr_pkg::OP_ROWPOS: begin
                        r_col  <= r_cur_col;
                        r_page <= r_cur_page + 3'd1;
                    end
                    default: begin
                        r_col  <= r_cur_col + step;
                        r_page <= r_start_page;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_cur_col  <= '0;
            r_cur_page <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
            case (i_cmd.op)
                sgpr_pkg::OP_SETPOS: begin
                    r_cur_col  <= r_tgt_col;
                    r_cur_page <= r_tgt_page;
                end
                sgpr_pkg::OP_ROWPOS: r_cur_page <= r_cur_page + 3'd1;
                sgpr_pkg::OP_FINAL: begin
                    r_cur_col  <= r_cur_col + step;
                    r_cur_page <= r_start_page;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid    = r_valid;
    assign o_kind         = r_kind;
    assign o_data_byte    = r_data;
    assign o_repeat_count = r_rep;
    assign o_out_column   = r_col;
    assign o_out_page     = r_page;
    assign o_last         = r_last;

    a_rowpos_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == sgpr_pkg::OP_ROWPOS) |=> (r_cur_page == $past(r_cur_page) + 3'd1))
        else $error("cursor page did not advance on a row end");

    a_final_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == sgpr_pkg::OP_FINAL) |=> (r_cur_page == $past(r_start_page)))
        else $error("cursor page not back at start page after glyph");

    a_setpos_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == sgpr_pkg::OP_SETPOS) |=> (r_cur_col == $past(r_tgt_col)))
        else $error("set position did not reach the cursor");

endmodule

[sv/scaled_glyph_page_renderer.sv]
// top level of the scaled glyph page renderer: 5x7 font character generator
// depends on sgpr_pkg, sgpr_ctrl and sgpr_dp
//
// usage
//   slave channel s_axis: one beat per command. tuser is the opcode (set
//   position or put character); tdata carries char_code, scale,
//   target_column and target_page.
//   master channel m_axis: display beats. tuser = 1 for a set position
//   command, 0 for a data run (byte plus repeat count); tlast marks the
//   final beat caused by one input beat.
// results and throughput
//   an input beat is registered into the sequencer state and the glyph
//   registers; its results then leave one per cycle while m_axis_tready
//   is high. a set position gives 1 beat, a raw (1x) glyph 6, a 2x glyph
//   15, a 4x glyph 53 and an 8x glyph 57; an out of range character is
//   taken and gives nothing. the rate is set by the single output register,
//   which moves one result per cycle.
//   s_axis_tready is high whenever the sequencer is idle, also while the
//   last result of the previous beat still waits in the output register.
// reset
//   synchronous, active low: cursor goes to column 0, page 0, output empty
// stall
//   a low m_axis_tready holds a full output register and stalls the sequencer;
//   no result is lost or repeated
module scaled_glyph_page_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] char_code, [11:8] scale, [19:12] target_column, [22:20] target_page
    input  logic [23:0] s_axis_tdata,
    // [0] opcode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] data_byte, [11:8] repeat_count, [19:12] out_column, [22:20] out_page
    output logic [23:0] m_axis_tdata,
    // [0] kind
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    sgpr_pkg::t_dp_cmd cmd;
    logic              out_free;
    logic [7:0]        data_byte;
    logic [3:0]        repeat_count;
    logic [7:0]        out_column;
    logic [2:0]        out_page;

    // sequencer: decodes the command beat and walks pages, columns and runs
    sgpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_opcode    (s_axis_tuser),
        .i_char_code (s_axis_tdata[7:0]),
        .i_scale     (s_axis_tdata[11:8]),
        .i_out_free  (out_free),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (cmd)
    );

    // datapath: font lookup, stretch, cursor and the output register
    sgpr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_char_code     (s_axis_tdata[7:0]),
        .i_target_column (s_axis_tdata[19:12]),
        .i_target_page   (s_axis_tdata[22:20]),
        .i_out_ready     (m_axis_tready),
        .o_out_free      (out_free),
        .o_out_valid     (m_axis_tvalid),
        .o_kind          (m_axis_tuser),
        .o_data_byte     (data_byte),
        .o_repeat_count  (repeat_count),
        .o_out_column    (out_column),
        .o_out_page      (out_page),
        .o_last          (m_axis_tlast)
    );

    // pack result fields, lowest field first, padded to whole bytes
    assign m_axis_tdata = {1'b0, out_page, out_column, repeat_count, data_byte};

endmodule

[dv/tb_scaled_glyph_page_renderer.sv]
`timescale 1ns / 100ps
// self-checking testbench of the scaled glyph page renderer
// depends on sgpr_pkg and scaled_glyph_page_renderer; needs no files or arguments
module tb_scaled_glyph_page_renderer;

    // scale codes as they travel in the scale field of a character beat
    localparam logic [3:0] SC_RAW0 = 4'd0;
    localparam logic [3:0] SC_RAW1 = 4'd1;
    localparam logic [3:0] SC_X2   = 4'd2;
    localparam logic [3:0] SC_RAW3 = 4'd3;
    localparam logic [3:0] SC_X4   = 4'd4;
    localparam logic [3:0] SC_X8   = 4'd8;
    localparam logic [3:0] SC_TOP  = 4'd15;

    // column advance and run length per stretch mode
    localparam logic [7:0] ADV_X8  = 8'd48;
    localparam logic [7:0] ADV_X4  = 8'd24;
    localparam logic [7:0] ADV_X2  = 8'd12;
    localparam logic [3:0] RUN_X8  = 4'd8;
    localparam logic [3:0] RUN_X4  = 4'd3;
    localparam logic [3:0] RUN_X2  = 4'd2;
    localparam logic [3:0] RUN_ONE = 4'd1;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 20;

    // font: one 40-bit word per glyph, leftmost column in the top byte, bit0 at the top
    localparam logic [0:95][39:0] GLYPHS = {
        40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
        40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
        40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
        40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
        40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
        40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
        40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h08082a0808,
        40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h7846414678
    };

    // one display beat as it should leave the block
    typedef struct packed {
        logic       kind;
        logic [7:0] pix;
        logic [3:0] reps;
        logic [7:0] col;
        logic [2:0] page;
        logic       last;
    } t_disp_beat;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] char_code, [11:8] scale, [19:12] target_column, [22:20] target_page
    logic [23:0] s_axis_tdata = '0;
    // [0] opcode
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] data_byte, [11:8] repeat_count, [19:12] out_column, [22:20] out_page
    logic [23:0] m_axis_tdata;
    // [0] kind
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // cursor as the display should see it
    logic [7:0]  cursor_col = '0;
    logic [2:0]  cursor_page = '0;

    // display beats still owed by the block, oldest first
    t_disp_beat  owed_beats[$];

    bit          idling_on = 1'b1;
    int          stall_left = 0;
    int          fail_count = 0;
    int          beat_count = 0;
    int          cycle_count = 0;

    scaled_glyph_page_renderer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // prediction of the display beats
    // ---------------------------------------------------------------

    // glyph bits spread over the rows of a page, per stretch mode
    function automatic logic [7:0] stretch_column(input logic [7:0] colbits,
                                                  input logic [3:0] sc, input int row);
        logic [7:0] s;
        s = '0;
        if (sc == SC_X8) begin
            if (colbits[row]) s = 8'hff;
        end else if (sc == SC_X4) begin
            if (colbits[2*row])     s = s | 8'h07;
            if (colbits[2*row + 1]) s = s | 8'h70;
        end else begin
            for (int k = 0; k < 4; k++)
                if (colbits[4*row + k]) s = s | (8'h03 << (2*k));
        end
        return s;
    endfunction

    function automatic void owe_run(input logic [7:0] pix, input logic [3:0] reps,
                                    input logic last);
        t_disp_beat b;
        b = '{kind: sgpr_pkg::KIND_RUN, pix: pix, reps: reps, col: 8'd0, page: 3'd0,
              last: last};
        owed_beats.push_back(b);
    endfunction

    // a position command also moves the cursor
    function automatic void owe_position(input logic [7:0] col, input logic [2:0] page,
                                         input logic last);
        t_disp_beat b;
        cursor_col  = col;
        cursor_page = page;
        b = '{kind: sgpr_pkg::KIND_POS, pix: 8'd0, reps: 4'd0, col: col, page: page,
              last: last};
        owed_beats.push_back(b);
    endfunction

    // works out every display beat that one accepted command causes
    function automatic void render_command(input logic op, input logic [7:0] code,
                                           input logic [3:0] sc, input logic [7:0] tcol,
                                           input logic [2:0] tpage);
        logic [39:0] word;
        logic [7:0]  glyph_col[6];
        int          rows;
        logic [3:0]  reps;
        logic [7:0]  adv;
        logic [7:0]  start_col;
        logic [2:0]  start_page;
        if (op == sgpr_pkg::OPC_SETPOS) begin
            owe_position(tcol, tpage, 1'b1);
        end else if (code >= sgpr_pkg::CHAR_FIRST && code <= sgpr_pkg::CHAR_LAST) begin
            word = GLYPHS[code - sgpr_pkg::CHAR_FIRST];
            for (int i = 0; i < 5; i++) glyph_col[i] = word[39 - 8*i -: 8];
            glyph_col[5] = 8'h00;   // spacer column
            if (sc == SC_X8 || sc == SC_X4 || sc == SC_X2) begin
                rows = int'(sc);
                reps = (sc == SC_X8) ? RUN_X8 : (sc == SC_X4) ? RUN_X4 : RUN_X2;
                adv  = (sc == SC_X8) ? ADV_X8 : (sc == SC_X4) ? ADV_X4 : ADV_X2;
                start_col  = cursor_col;
                start_page = cursor_page;
                for (int row = 0; row < rows; row++) begin
                    for (int i = 0; i < 6; i++) begin
                        owe_run(stretch_column(glyph_col[i], sc, row), reps, 1'b0);
                        // 4x leaves one blank column after each lit triple, never merged
                        if (sc == SC_X4) owe_run(8'h00, RUN_ONE, 1'b0);
                    end
                    owe_position(cursor_col, cursor_page + 3'd1, 1'b0);
                end
                // back to the start page, column moved on and wrapping at 256
                owe_position(start_col + adv, start_page, 1'b1);
            end else begin
                // plain 1x glyph, cursor untouched
                for (int i = 0; i < 6; i++) owe_run(glyph_col[i], RUN_ONE, i == 5);
            end
        end
        // out of range characters give nothing and leave the cursor alone
    endfunction

    // ---------------------------------------------------------------
    // command side: one beat per call, entered and left at a falling edge
    // ---------------------------------------------------------------
    task automatic send_command(input logic op, input logic [7:0] code, input logic [3:0] sc,
                                input logic [7:0] tcol, input logic [2:0] tpage);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, tpage, tcol, sc, code};
        do @(posedge i_clk); while (!s_axis_tready);
        render_command(op, code, sc, tcol, tpage);
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // display side: random back-pressure in bursts
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // one line per mismatch, all are counted
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("display beat %0d: %s got 0x%0h want 0x%0h (cycle %0d)",
                 beat_count, what, got, want, cycle_count);
        fail_count++;
    endtask

    // every display beat against the oldest owed one, field by field
    always @(posedge i_clk) begin : check_display
        t_disp_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (owed_beats.size() == 0) begin
                report_mismatch("beat with nothing owed, tdata", m_axis_tdata, 0);
            end else begin
                want = owed_beats.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("kind", m_axis_tuser, want.kind);
                if (m_axis_tdata[7:0] !== want.pix)
                    report_mismatch("data_byte", m_axis_tdata[7:0], want.pix);
                if (m_axis_tdata[11:8] !== want.reps)
                    report_mismatch("repeat_count", m_axis_tdata[11:8], want.reps);
                if (m_axis_tdata[19:12] !== want.col)
                    report_mismatch("out_column", m_axis_tdata[19:12], want.col);
                if (m_axis_tdata[22:20] !== want.page)
                    report_mismatch("out_page", m_axis_tdata[22:20], want.page);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", m_axis_tlast, want.last);
                if (m_axis_tdata[23] !== 1'b0)
                    report_mismatch("pad bit", m_axis_tdata[23], 0);
            end
            beat_count++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // position commands at the corners and with alternating bits
    task automatic test_set_position();
        send_command(sgpr_pkg::OPC_SETPOS, 8'h00, SC_RAW0, 8'd0,   3'd0);
        send_command(sgpr_pkg::OPC_SETPOS, 8'hff, SC_TOP,  8'd255, 3'd7);
        send_command(sgpr_pkg::OPC_SETPOS, 8'h5a, SC_X4,   8'ha5,  3'd5);
        send_command(sgpr_pkg::OPC_SETPOS, 8'ha5, SC_X2,   8'h5a,  3'd2);
    endtask

    // every scale that is not a stretch gives the raw six bytes
    task automatic test_raw_glyphs();
        send_command(sgpr_pkg::OPC_PUTCH, sgpr_pkg::CHAR_FIRST, SC_RAW0, 8'hff, 3'd7);
        send_command(sgpr_pkg::OPC_PUTCH, sgpr_pkg::CHAR_LAST,  SC_RAW1, 8'h00, 3'd0);
        send_command(sgpr_pkg::OPC_PUTCH, 8'h41,                SC_RAW3, 8'h3c, 3'd3);
        send_command(sgpr_pkg::OPC_PUTCH, 8'h7e,                SC_TOP,  8'hc3, 3'd4);
    endtask

    // stretched glyphs, starting near the right edge and on the bottom page so
    // that both the column and the page wrap
    task automatic test_stretch_scales();
        send_command(sgpr_pkg::OPC_SETPOS, 8'h00, SC_RAW0, 8'd250, 3'd7);
        send_command(sgpr_pkg::OPC_PUTCH,  sgpr_pkg::CHAR_LAST,  SC_X8, 8'h00, 3'd0);
        send_command(sgpr_pkg::OPC_PUTCH,  8'h40,                SC_X4, 8'h00, 3'd0);
        send_command(sgpr_pkg::OPC_PUTCH,  8'h57,                SC_X2, 8'h00, 3'd0);
        send_command(sgpr_pkg::OPC_PUTCH,  sgpr_pkg::CHAR_FIRST, SC_X8, 8'h00, 3'd0);
        send_command(sgpr_pkg::OPC_SETPOS, 8'h00, SC_RAW0, 8'd240, 3'd6);
        send_command(sgpr_pkg::OPC_PUTCH,  8'h23,                SC_X4, 8'h00, 3'd0);
        send_command(sgpr_pkg::OPC_PUTCH,  8'h4d,                SC_X2, 8'h00, 3'd0);
    endtask

    // codes outside the font: nothing comes out, cursor stays put
    task automatic test_out_of_range();
        send_command(sgpr_pkg::OPC_PUTCH, 8'h00, SC_RAW1, 8'h00, 3'd0);
        send_command(sgpr_pkg::OPC_PUTCH, 8'h1f, SC_X2,   8'h11, 3'd1);
        send_command(sgpr_pkg::OPC_PUTCH, 8'h80, SC_X4,   8'h22, 3'd2);
        send_command(sgpr_pkg::OPC_PUTCH, 8'hff, SC_X8,   8'h33, 3'd3);
        // a printable one right after proves the cursor survived
        send_command(sgpr_pkg::OPC_PUTCH, 8'h31, SC_X2,   8'h00, 3'd0);
    endtask

    // mostly printable characters at the stretch scales, with position moves,
    // odd scales and some codes outside the font mixed in
    task automatic test_random_traffic(input int count);
        int         pick;
        int         done;
        logic [7:0] code;
        logic [3:0] sc;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                send_command(sgpr_pkg::OPC_SETPOS, 8'($urandom_range(0, 255)),
                             4'($urandom_range(0, 15)),
                             8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
                done++;
            end else if (pick < 26) begin
                // ignored by the block, so not counted
                code = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                            : 8'($urandom_range(128, 255));
                send_command(sgpr_pkg::OPC_PUTCH, code, 4'($urandom_range(0, 15)),
                             8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
            end else begin
                code = 8'($urandom_range(32, 127));
                pick = $urandom_range(0, 9);
                sc = (pick < 3) ? SC_X8 : (pick < 6) ? SC_X4 : (pick < 8) ? SC_X2
                                : 4'($urandom_range(0, 15));
                send_command(sgpr_pkg::OPC_PUTCH, code, sc,
                             8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
                done++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_set_position();
        test_raw_glyphs();
        test_stretch_scales();
        test_out_of_range();
        test_random_traffic(200);
        // closing stretch with both sides running flat out
        idling_on = 1'b0;
        test_random_traffic(40);
        s_axis_tvalid <= 1'b0;

        while (owed_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
